// ===== rtl/core/dnsar_pkg.sv =====
package dnsar_pkg;

  // Fixed layout of a DNS message and of an answer record.
  localparam int unsigned HeaderBytes   = 12;
  localparam int unsigned RcodePos      = 3;
  localparam int unsigned AncountHiPos  = 6;
  localparam int unsigned AncountLoPos  = 7;
  localparam int unsigned HeaderLastPos = 11;
  localparam int unsigned QtailBytes    = 4;
  localparam int unsigned QptrTailBytes = 5;
  localparam int unsigned FixedKindHi   = 0;
  localparam int unsigned FixedKindLo   = 1;
  localparam int unsigned FixedLenHi    = 8;
  localparam int unsigned FixedLenLo    = 9;
  localparam int unsigned AddrBytes     = 4;
  localparam logic [15:0] KindA         = 16'd1;

  localparam logic [7:0] PtrMask   = 8'hC0;
  localparam logic [7:0] RcodeMask = 8'h0F;

  // Result status codes.
  localparam logic [2:0] StatusFound     = 3'd0;
  localparam logic [2:0] StatusShort     = 3'd1;
  localparam logic [2:0] StatusRcode     = 3'd2;
  localparam logic [2:0] StatusNoAnswers = 3'd3;
  localparam logic [2:0] StatusNoA       = 3'd4;

  // Parser phases.
  typedef enum logic [3:0] {
    PhHeader,
    PhQname,
    PhQlabelSkip,
    PhQtailSkip,
    PhAnameFirst,
    PhAnameRest,
    PhAlabelSkip,
    PhAptrSkip,
    PhAfixed,
    PhAdataSkip,
    PhAaddr,
    PhDone
  } phase_t;

endpackage

// ===== rtl/core/dns_response_a_record_parser_top.sv =====
// Channel   Direction  Transaction                 Payload
// s_axis    in         one message byte            tdata = data_byte, tlast = last_byte
// m_axis    out        one result per message      tdata = status, ipv4_address
// cfg       in         write of ipv4_allowed       cfg_data = ipv4_allowed
//
// Each byte is parsed by the logic between the parser state registers and the
// result register, so a byte can be taken every cycle while the input does not stall.
// The result of a message is loaded into the output register with its last byte.
// Input stalls only while that register is full and not being taken.
// Reset (rst, synchronous) clears the parser and sets ipv4_allowed to 1.
module dns_response_a_record_parser_top
  import dnsar_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [2:0] status, [34:3] ipv4_address, [39:35] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data        // ipv4_allowed
);

  localparam int unsigned PosW = $clog2(MAX_MESSAGE_BYTES + 1);

  logic            ipv4_allowed;
  logic [PosW-1:0] byte_position;
  phase_t          parse_phase;
  logic [15:0]     skip_remaining;
  logic [3:0]      response_code;
  logic [15:0]     answer_total;
  logic [15:0]     answers_done;
  logic [15:0]     record_kind;
  logic [15:0]     record_data_length;
  logic [3:0]      field_index;
  logic [31:0]     address_accum;
  logic            address_found;

  phase_t          parse_phase_next;
  logic [PosW-1:0] byte_position_next;
  logic [15:0]     skip_remaining_next;
  logic [3:0]      response_code_next;
  logic [15:0]     answer_total_next;
  logic [15:0]     answers_done_next;
  logic [15:0]     record_kind_next;
  logic [15:0]     record_data_length_next;
  logic [3:0]      field_index_next;
  logic [31:0]     address_accum_next;
  logic            address_found_next;

  logic            accept;
  logic            parse_en;
  logic [7:0]      b;
  logic [15:0]     skip_dec;
  logic            skip_done;
  logic            is_ptr;
  logic            is_zero;
  logic [15:0]     len_full;
  logic            a_match;
  logic            answers_over;

  logic [2:0]      out_status;
  logic [31:0]     out_addr;
  logic [2:0]      status_next;
  logic [31:0]     addr_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign parse_en      = byte_position < PosW'(MAX_MESSAGE_BYTES);

  // Shared decodes of the incoming byte and the current state.
  assign b            = s_axis_tdata;
  assign skip_dec     = skip_remaining - 16'd1;
  assign skip_done    = skip_dec == 16'd0;
  assign is_ptr       = (b & PtrMask) == PtrMask;
  assign is_zero      = b == 8'd0;
  assign len_full     = {record_data_length[15:8], b};
  assign a_match      = ipv4_allowed && record_kind == KindA && len_full == 16'(AddrBytes);
  assign answers_over = answers_done >= answer_total;

  // Next parser phase.
  always_comb begin
    parse_phase_next = parse_phase;
    unique case (parse_phase)
      PhHeader: begin
        if (byte_position == PosW'(HeaderLastPos)) parse_phase_next = PhQname;
      end
      PhQname: begin
        parse_phase_next = (is_zero || is_ptr) ? PhQtailSkip : PhQlabelSkip;
      end
      PhQlabelSkip: begin
        if (skip_done) parse_phase_next = PhQname;
      end
      PhQtailSkip: begin
        if (skip_done) parse_phase_next = PhAnameFirst;
      end
      PhAlabelSkip: begin
        if (skip_done) parse_phase_next = PhAnameRest;
      end
      PhAptrSkip: begin
        if (skip_done) parse_phase_next = PhAfixed;
      end
      PhAdataSkip: begin
        if (skip_done) parse_phase_next = PhAnameFirst;
      end
      PhAnameFirst: begin
        if (answers_over) parse_phase_next = PhDone;
        else if (is_ptr)  parse_phase_next = PhAptrSkip;
        else if (is_zero) parse_phase_next = PhAfixed;
        else              parse_phase_next = PhAlabelSkip;
      end
      PhAnameRest: begin
        parse_phase_next = is_zero ? PhAfixed : PhAlabelSkip;
      end
      PhAfixed: begin
        if (field_index == 4'(FixedLenLo)) begin
          if (a_match)                    parse_phase_next = PhAaddr;
          else if (len_full == 16'd0)     parse_phase_next = PhAnameFirst;
          else                            parse_phase_next = PhAdataSkip;
        end
      end
      PhAaddr: begin
        if (field_index == 4'(AddrBytes - 1)) parse_phase_next = PhDone;
      end
      PhDone: begin
        parse_phase_next = PhDone;
      end
      default: parse_phase_next = PhDone;
    endcase
  end

  // Datapath updates for the current byte.
  always_comb begin
    skip_remaining_next     = skip_remaining;
    response_code_next      = response_code;
    answer_total_next       = answer_total;
    answers_done_next       = answers_done;
    record_kind_next        = record_kind;
    record_data_length_next = record_data_length;
    field_index_next        = field_index;
    address_accum_next      = address_accum;
    address_found_next      = address_found;
    unique case (parse_phase)
      PhHeader: begin
        if (byte_position == PosW'(RcodePos))     response_code_next = 4'(b & RcodeMask);
        if (byte_position == PosW'(AncountHiPos)) answer_total_next = {b, 8'd0};
        if (byte_position == PosW'(AncountLoPos)) answer_total_next = {answer_total[15:8], b};
      end
      PhQname: begin
        field_index_next = 4'd0;
        if (is_zero)     skip_remaining_next = 16'(QtailBytes);
        else if (is_ptr) skip_remaining_next = 16'(QptrTailBytes);
        else             skip_remaining_next = {8'd0, b};
      end
      PhQlabelSkip, PhQtailSkip, PhAlabelSkip, PhAptrSkip, PhAdataSkip: begin
        skip_remaining_next = skip_dec;
        if (skip_done) field_index_next = 4'd0;
      end
      PhAnameFirst: begin
        if (!answers_over) begin
          answers_done_next = answers_done + 16'd1;
          field_index_next  = 4'd0;
          if (is_ptr)        skip_remaining_next = 16'd1;
          else if (!is_zero) skip_remaining_next = {8'd0, b};
        end
      end
      PhAnameRest: begin
        field_index_next = 4'd0;
        if (!is_zero) skip_remaining_next = {8'd0, b};
      end
      PhAfixed: begin
        if (field_index == 4'(FixedKindHi)) record_kind_next = {b, 8'd0};
        if (field_index == 4'(FixedKindLo)) record_kind_next = {record_kind[15:8], b};
        if (field_index == 4'(FixedLenHi))  record_data_length_next = {b, 8'd0};
        if (field_index == 4'(FixedLenLo)) begin
          record_data_length_next = len_full;
          field_index_next        = 4'd0;
          if (a_match)                 address_accum_next = 32'd0;
          else if (len_full != 16'd0)  skip_remaining_next = len_full;
        end else begin
          field_index_next = field_index + 4'd1;
        end
      end
      PhAaddr: begin
        address_accum_next = {address_accum[23:0], b};
        field_index_next   = field_index + 4'd1;
        if (field_index == 4'(AddrBytes - 1)) address_found_next = 1'b1;
      end
      PhDone: begin
        field_index_next = field_index;
      end
      default: field_index_next = field_index;
    endcase
  end

  // Result of a message, taken from the state after its last byte.
  always_comb begin
    byte_position_next = parse_en ? byte_position + PosW'(1) : byte_position;
    addr_next          = 32'd0;
    if (byte_position_next < PosW'(HeaderBytes)) begin
      status_next = StatusShort;
    end else if ((parse_en ? response_code_next : response_code) != 4'd0) begin
      status_next = StatusRcode;
    end else if ((parse_en ? answer_total_next : answer_total) == 16'd0) begin
      status_next = StatusNoAnswers;
    end else if (parse_en ? address_found_next : address_found) begin
      status_next = StatusFound;
      addr_next   = parse_en ? address_accum_next : address_accum;
    end else begin
      status_next = StatusNoA;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ipv4_allowed <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      ipv4_allowed <= cfg_data;
    end
  end

  // Parser state; every message ends with a return to the reset state.
  always_ff @(posedge clk) begin
    if (rst || (accept && s_axis_tlast)) begin
      byte_position      <= '0;
      parse_phase        <= PhHeader;
      skip_remaining     <= 16'd0;
      response_code      <= 4'd0;
      answer_total       <= 16'd0;
      answers_done       <= 16'd0;
      record_kind        <= 16'd0;
      record_data_length <= 16'd0;
      field_index        <= 4'd0;
      address_accum      <= 32'd0;
      address_found      <= 1'b0;
    end else if (accept && parse_en) begin
      byte_position      <= byte_position_next;
      parse_phase        <= parse_phase_next;
      skip_remaining     <= skip_remaining_next;
      response_code      <= response_code_next;
      answer_total       <= answer_total_next;
      answers_done       <= answers_done_next;
      record_kind        <= record_kind_next;
      record_data_length <= record_data_length_next;
      field_index        <= field_index_next;
      address_accum      <= address_accum_next;
      address_found      <= address_found_next;
    end
  end

  // Output register: loaded with the last byte of a message, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast) begin
      out_status <= status_next;
      out_addr   <= addr_next;
    end
  end

  assign m_axis_tdata = {5'd0, out_addr, out_status};

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dnsar_pkg::*;

  localparam int unsigned MsgMax       = 512;
  localparam int unsigned IdlePct      = 34;
  localparam int unsigned HoldCycles   = 250;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 8;
  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned DataCap      = 40;

  // One result transaction: status and address as carried on the output bus.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr;
  } a_result_t;

  // What the next message is to produce, when it is typed in by hand.
  typedef struct {
    bit        typed;
    a_result_t want;
  } reply_plan_t;

  // A directed message, described by the parts of a DNS response.
  typedef struct {
    bit          allow;     // ipv4_allowed while this message runs
    logic [7:0]  flags;     // header byte 3, response code in the low nibble
    logic [15:0] ancount;
    logic [7:0]  qlabel;    // 0 root name, C0 and up a pointer, else one label
    logic [15:0] kind1;     // type of the first answer, named by a pointer
    logic [15:0] dlen1;     // its data length
    bit          add_a;     // append an A record named by labels
    logic [7:0]  rlabel;    // second label length in that name, 0 for none
    logic [31:0] addr;      // address bytes placed in the records
    int          cut;       // above 0 keeps that many bytes, below 0 drops from the end
    int          pad;       // random bytes after the records
    bit          typed;
    logic [2:0]  status;
    logic [31:0] want_addr;
  } probe_t;

  typedef enum logic [1:0] {StDirected, StHoldOff, StDisabled, StCalm} stage_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  stage_t stage;
  int     msgs_sent;
  int     results_seen;
  int     fails;
  int     quiet;

  a_result_t   replies_due[$];
  reply_plan_t reply_plans[$];

  // Shadow of the parser state.
  bit          allow_a;
  int          walk_pos;
  phase_t      walk_ph;
  logic [15:0] skip_left;
  logic [3:0]  rcode;
  logic [15:0] an_total;
  logic [15:0] an_started;
  logic [15:0] rr_kind;
  logic [15:0] rr_len;
  logic [3:0]  fidx;
  logic [31:0] acc;
  bit          have_addr;

  probe_t probes [19] = '{
    // allow flags  ancount  qlabel kind1   dlen1   add_a rlabel addr  cut pad typed status want_addr
    '{1, 8'h00, 16'd1, 8'd3, 16'd1, 16'd4, 0, 8'd0, 32'h0, 1, 0, 1, StatusShort, 32'h0},
    '{1, 8'h00, 16'd1, 8'd3, 16'd1, 16'd4, 0, 8'd0, 32'h0, 11, 0, 1, StatusShort, 32'h0},
    '{1, 8'h8F, 16'd1, 8'd3, 16'd1, 16'd4, 0, 8'd0, 32'h0, 0, 0, 1, StatusRcode, 32'h0},
    '{1, 8'h00, 16'd0, 8'd3, 16'd1, 16'd4, 0, 8'd0, 32'h0, 12, 0, 1, StatusNoAnswers, 32'h0},
    '{1, 8'h00, 16'd0, 8'd3, 16'd1, 16'd4, 0, 8'd0, 32'h1, 0, 0, 1, StatusNoAnswers, 32'h0},
    '{1, 8'hF0, 16'd1, 8'd3, 16'd1, 16'd4, 0, 8'd0, 32'hFFFFFFFF, 0, 0,
      1, StatusFound, 32'hFFFFFFFF},
    '{1, 8'h00, 16'd1, 8'hC0, 16'd1, 16'd4, 0, 8'd0, 32'h0, 0, 0, 1, StatusFound, 32'h0},
    '{1, 8'h00, 16'hFFFF, 8'd0, 16'd5, 16'd6, 1, 8'd0, 32'h0A000001, 0, 0, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd1, 8'd3, 16'd5, 16'd3, 1, 8'd0, 32'h0A000002, 0, 0, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd2, 8'd3, 16'd1, 16'd16, 1, 8'd0, 32'hC0A80101, 0, 0, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd3, 8'd3, 16'd28, 16'd16, 1, 8'hC3, 32'h7F000001, 0, 0, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd1, 8'h45, 16'd1, 16'd4, 0, 8'd0, 32'h01020304, 0, 0, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd1, 8'hBF, 16'd1, 16'd4, 0, 8'd0, 32'h55AA55AA, 0, 0, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd1, 8'd3, 16'd1, 16'd4, 0, 8'd0, 32'h11223344, -2, 0, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd1, 8'd3, 16'd1, 16'd4, 0, 8'd0, 32'h11223344, -9, 0, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd2, 8'd3, 16'd5, 16'd40, 1, 8'd0, 32'hAABBCCDD, 0, 0, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd1, 8'd3, 16'd1, 16'd4, 0, 8'd0, 32'h89ABCDEF, 0, 490, 0, 3'd0, 32'h0},
    '{1, 8'h00, 16'd1, 8'd3, 16'hFFFF, 16'hFFFF, 0, 8'd0, 32'h0, 0, 0, 0, 3'd0, 32'h0},
    '{0, 8'h00, 16'd1, 8'd3, 16'd1, 16'd4, 1, 8'd0, 32'h0A0B0C0D, 0, 0, 1, StatusNoA, 32'h0}
  };

  dns_response_a_record_parser_top #(
    .MAX_MESSAGE_BYTES(MsgMax)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Return the shadow parser to the start of a message; the register is kept.
  task automatic clear_walk();
    walk_pos   = 0;
    walk_ph    = PhHeader;
    skip_left  = '0;
    rcode      = '0;
    an_total   = '0;
    an_started = '0;
    rr_kind    = '0;
    rr_len     = '0;
    fidx       = '0;
    acc        = '0;
    have_addr  = 1'b0;
  endtask

  function automatic phase_t resume_after(phase_t p);
    case (p)
      PhQlabelSkip: return PhQname;
      PhQtailSkip:  return PhAnameFirst;
      PhAlabelSkip: return PhAnameRest;
      PhAptrSkip:   return PhAfixed;
      PhAdataSkip:  return PhAnameFirst;
      default:      return PhDone;
    endcase
  endfunction

  task automatic skip_into(phase_t p, logic [15:0] n);
    fidx = '0;
    if (n == 16'd0) begin
      walk_ph = resume_after(p);
    end else begin
      skip_left = n;
      walk_ph   = p;
    end
  endtask

  // Only the first byte of an answer name may be a pointer.
  task automatic answer_name(logic [7:0] b, bit first);
    if (first && (b & PtrMask) == PtrMask) begin
      skip_into(PhAptrSkip, 16'd1);
    end else if (b == 8'd0) begin
      skip_into(PhAptrSkip, 16'd0);
    end else begin
      skip_into(PhAlabelSkip, {8'd0, b});
    end
  endtask

  task automatic walk_byte(logic [7:0] b);
    case (walk_ph)
      PhHeader: begin
        if (walk_pos == RcodePos) rcode = 4'(b & RcodeMask);
        if (walk_pos == AncountHiPos) an_total = {b, 8'd0};
        if (walk_pos == AncountLoPos) an_total = an_total | {8'd0, b};
        if (walk_pos == HeaderLastPos) walk_ph = PhQname;
      end
      PhQname: begin
        if (b == 8'd0) begin
          skip_into(PhQtailSkip, 16'(QtailBytes));
        end else if ((b & PtrMask) == PtrMask) begin
          skip_into(PhQtailSkip, 16'(QptrTailBytes));
        end else begin
          skip_into(PhQlabelSkip, {8'd0, b});
        end
      end
      PhQlabelSkip, PhQtailSkip, PhAlabelSkip, PhAptrSkip, PhAdataSkip: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) begin
          fidx    = '0;
          walk_ph = resume_after(walk_ph);
        end
      end
      PhAnameFirst: begin
        if (an_started >= an_total) begin
          walk_ph = PhDone;
        end else begin
          an_started = an_started + 16'd1;
          answer_name(b, 1'b1);
        end
      end
      PhAnameRest: answer_name(b, 1'b0);
      PhAfixed: begin
        if (fidx == FixedKindHi) rr_kind = {b, 8'd0};
        if (fidx == FixedKindLo) rr_kind = rr_kind | {8'd0, b};
        if (fidx == FixedLenHi) rr_len = {b, 8'd0};
        if (fidx == FixedLenLo) begin
          rr_len = rr_len | {8'd0, b};
          if (allow_a && rr_kind == KindA && rr_len == AddrBytes) begin
            fidx    = '0;
            acc     = '0;
            walk_ph = PhAaddr;
          end else begin
            skip_into(PhAdataSkip, rr_len);
          end
        end else begin
          fidx = fidx + 4'd1;
        end
      end
      PhAaddr: begin
        acc  = {acc[23:0], b};
        fidx = fidx + 4'd1;
        if (fidx == AddrBytes) begin
          have_addr = 1'b1;
          walk_ph   = PhDone;
        end
      end
      default: ;
    endcase
  endtask

  // Advance the shadow parser by one accepted byte and, on the last byte,
  // queue the result that the message should produce.
  task automatic walk_message_byte(logic [7:0] b, bit last);
    a_result_t   r;
    reply_plan_t p;
    if (walk_pos < MsgMax) begin
      walk_byte(b);
      walk_pos++;
    end
    if (last) begin
      r.addr = '0;
      if (walk_pos < HeaderBytes) begin
        r.status = StatusShort;
      end else if (rcode != 4'd0) begin
        r.status = StatusRcode;
      end else if (an_total == 16'd0) begin
        r.status = StatusNoAnswers;
      end else if (have_addr) begin
        r.status = StatusFound;
        r.addr   = acc;
      end else begin
        r.status = StatusNoA;
      end
      p = reply_plans.pop_front();
      replies_due.push_back(p.typed ? p.want : r);
      clear_walk();
    end
  endtask

  // Compare each result transaction with the oldest expectation, then track
  // the input and configuration transactions of the same edge.
  always @(posedge clk) begin : check
    a_result_t want;
    a_result_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status   = m_axis_tdata[2:0];
        got.addr     = m_axis_tdata[34:3];
        results_seen <= results_seen + 1;
        if (replies_due.size() == 0) begin
          $error("unexpected result: status %0d, ipv4_address %h", got.status, got.addr);
          fails++;
        end else begin
          want = replies_due.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
          if (got.addr != want.addr) begin
            $error("ipv4_address: expected %h, got %h", want.addr, got.addr);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) walk_message_byte(s_axis_tdata, s_axis_tlast);
      if (cfg_valid && cfg_ready) allow_a = cfg_data;
    end
  end

  // End the run if no transaction of any kind completes for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QuietLimit) begin
      $display("** dns_response_a_record_parser_top: FAILED **");
      $finish;
    end
  end

  // Result receiver: random back-pressure, one long hold-off, none while calm.
  initial begin : sink
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stage == StHoldOff && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_axis_tready <= (stage == StCalm) || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    while (stage != StCalm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_message(ref logic [7:0] m[$], input bit typed, input a_result_t want);
    reply_plans.push_back('{typed, want});
    foreach (m[i]) send_byte(m[i], i == m.size() - 1);
    msgs_sent++;
  endtask

  // The register is only written once every result has been taken.
  task automatic set_ipv4_allowed(bit v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_seen != msgs_sent) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic build_probe(input probe_t p, ref logic [7:0] m[$]);
    int n;
    int k;
    int keep;
    m.delete();
    m.push_back(8'($urandom));
    m.push_back(8'($urandom));
    m.push_back(8'h81);
    m.push_back(p.flags);
    m.push_back(8'h00);
    m.push_back(8'h01);
    m.push_back(p.ancount[15:8]);
    m.push_back(p.ancount[7:0]);
    repeat (4) m.push_back(8'h00);
    // Question name, then type and class.
    if (p.qlabel >= PtrMask) begin
      m.push_back(p.qlabel);
      m.push_back(8'h0C);
    end else if (p.qlabel != 8'd0) begin
      m.push_back(p.qlabel);
      repeat (p.qlabel) m.push_back(8'($urandom));
      m.push_back(8'h00);
    end else begin
      m.push_back(8'h00);
    end
    m.push_back(8'h00);
    m.push_back(8'h01);
    m.push_back(8'h00);
    m.push_back(8'h01);
    // First answer, named by a pointer to the question.
    m.push_back(8'hC0);
    m.push_back(8'h0C);
    m.push_back(p.kind1[15:8]);
    m.push_back(p.kind1[7:0]);
    m.push_back(8'h00);
    m.push_back(8'h01);
    repeat (4) m.push_back(8'($urandom));
    m.push_back(p.dlen1[15:8]);
    m.push_back(p.dlen1[7:0]);
    n = (p.dlen1 > DataCap) ? DataCap : p.dlen1;
    for (k = 0; k < n; k++) m.push_back((k < 4) ? p.addr[31 - 8 * k -: 8] : 8'($urandom));
    // Optional A record whose name is a run of labels.
    if (p.add_a) begin
      m.push_back(8'h02);
      m.push_back(8'($urandom));
      m.push_back(8'($urandom));
      if (p.rlabel != 8'd0) begin
        m.push_back(p.rlabel);
        repeat (p.rlabel) m.push_back(8'($urandom));
      end
      m.push_back(8'h00);
      m.push_back(8'h00);
      m.push_back(8'h01);
      m.push_back(8'h00);
      m.push_back(8'h01);
      repeat (4) m.push_back(8'($urandom));
      m.push_back(8'h00);
      m.push_back(8'h04);
      for (k = 0; k < 4; k++) m.push_back(p.addr[31 - 8 * k -: 8]);
    end
    repeat (p.pad) m.push_back(8'($urandom));
    keep = (p.cut > 0) ? p.cut : m.size() + p.cut;
    while (m.size() > keep) void'(m.pop_back());
  endtask

  // Mostly well-formed responses with random content, some noise and some
  // messages cut short at a random byte.
  task automatic random_message(ref logic [7:0] m[$]);
    int          k;
    int          n_rec;
    int          len;
    int          sel;
    logic [15:0] ancount;
    logic [15:0] kind;
    logic [15:0] dlen;
    m.delete();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(1, 40)) m.push_back(8'($urandom));
      return;
    end
    sel = $urandom_range(99);
    if (sel < 5) ancount = 16'd0;
    else if (sel < 9) ancount = 16'hFFFF;
    else ancount = 16'($urandom_range(1, 4));
    repeat (3) m.push_back(8'($urandom));
    if ($urandom_range(99) < 10) m.push_back(8'($urandom));
    else m.push_back({4'($urandom), 4'd0});
    m.push_back(8'h00);
    m.push_back(8'h01);
    m.push_back(ancount[15:8]);
    m.push_back(ancount[7:0]);
    repeat (4) m.push_back(8'($urandom));
    // Question name: a pointer or up to three labels, long ones now and then.
    if ($urandom_range(99) < 30) begin
      m.push_back({2'b11, 6'($urandom)});
      m.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        len = ($urandom_range(99) < 8) ? $urandom_range(64, 191) : $urandom_range(1, 8);
        m.push_back(8'(len));
        repeat (len) m.push_back(8'($urandom));
      end
      m.push_back(8'h00);
    end
    repeat (4) m.push_back(8'($urandom));
    // Answer records, sometimes more than the header announces.
    n_rec = $urandom_range(0, 4);
    for (k = 0; k < n_rec; k++) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        m.push_back({2'b11, 6'($urandom)});
        m.push_back(8'($urandom));
      end else begin
        if (sel >= 60) begin
          len = $urandom_range(1, 6);
          m.push_back(8'(len));
          repeat (len) m.push_back(8'($urandom));
          if ($urandom_range(99) < 10) begin
            len = $urandom_range(192, 255);
            m.push_back(8'(len));
            repeat (len) m.push_back(8'($urandom));
          end
        end
        m.push_back(8'h00);
      end
      sel = $urandom_range(99);
      if (sel < 55) kind = KindA;
      else if (sel < 65) kind = 16'd5;
      else if (sel < 75) kind = 16'd28;
      else if (sel < 82) kind = 16'h0100;
      else if (sel < 88) kind = 16'hFFFF;
      else kind = 16'($urandom);
      dlen = (kind == KindA && $urandom_range(99) < 80) ? 16'd4 : 16'($urandom_range(0, 20));
      m.push_back(kind[15:8]);
      m.push_back(kind[7:0]);
      repeat (6) m.push_back(8'($urandom));
      m.push_back(dlen[15:8]);
      m.push_back(dlen[7:0]);
      repeat (dlen) m.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 2)) m.push_back(8'($urandom));
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(1, m.size());
      while (m.size() > len) void'(m.pop_back());
    end
  endtask

  task automatic run_random(stage_t s, bit allow);
    logic [7:0] msg[$];
    int         n_bytes;
    int         n_msgs;
    n_bytes = 0;
    n_msgs  = 0;
    set_ipv4_allowed(allow);
    stage <= s;
    while (n_bytes < 140 || n_msgs < 4) begin
      random_message(msg);
      send_message(msg, 1'b0, '0);
      n_bytes += msg.size();
      n_msgs++;
    end
  endtask

  // Reset, directed messages, then three random phases.
  initial begin : stimulus
    logic [7:0] msg[$];
    bit         allow_now;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    stage         = StDirected;
    msgs_sent     = 0;
    results_seen  = 0;
    fails         = 0;
    quiet         = 0;
    allow_a       = 1'b1;
    clear_walk();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_ipv4_allowed(1'b1);
    allow_now = 1'b1;
    foreach (probes[i]) begin
      if (probes[i].allow != allow_now) begin
        set_ipv4_allowed(probes[i].allow);
        allow_now = probes[i].allow;
      end
      build_probe(probes[i], msg);
      send_message(msg, probes[i].typed, '{probes[i].status, probes[i].want_addr});
    end

    run_random(StHoldOff, 1'b1);
    run_random(StDisabled, 1'b0);
    run_random(StCalm, 1'b1);

    // Drain the remaining results and allow for any stray output.
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_seen != msgs_sent) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fails == 0 && replies_due.size() == 0) begin
      $display("** dns_response_a_record_parser_top: PASSED **");
    end else begin
      $display("** dns_response_a_record_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
